FILE: sv/rds_pkg.sv
// ----------------------------------------------------------------------------
// rds_pkg: shared types and constants
// Word layouts, register indexes, opcodes and helpers for the stencil step.
// ----------------------------------------------------------------------------
package rds_pkg;

   localparam int MAX_COLS_DEF = 1024;
   localparam int MAX_ROWS     = 1024;
   localparam int DIM_W        = 11;
   localparam int CSR_W        = 16;
   localparam int JOBQ_DEPTH   = 2;
   localparam int NUM_TAPS     = 5;

   // Tap order inside a job: center, up, down, left, right.
   localparam int TAP_C = 0;
   localparam int TAP_U = 1;
   localparam int TAP_D = 2;
   localparam int TAP_L = 3;
   localparam int TAP_R = 4;

   typedef enum logic [1:0] {
      CSR_DIFF_RATE  = 2'd0,
      CSR_FRAME_ROWS = 2'd1,
      CSR_FRAME_COLS = 2'd2
   } csr_index_type;

   typedef enum logic {
      OP_CELL  = 1'b0,
      OP_DRAIN = 1'b1
   } rds_op_type;

   typedef struct packed {
      rds_op_type  opcode;
      logic [15:0] density;
      logic [15:0] capacity;
   } rds_req_type;

   typedef struct packed {
      logic [15:0]        new_density;
      logic signed [31:0] diffusion_term;
      logic signed [31:0] growth_term;
      logic               last_of_frame;
   } rds_rsp_type;

   typedef struct packed {
      logic [15:0] capacity;
      logic [15:0] density;
   } rds_cell_type;

   typedef struct packed {
      logic up;
      logic down;
      logic left;
      logic right;
      logic last;
   } rds_flags_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_READ,
      BK_LAP,
      BK_MUL,
      BK_DIV,
      BK_DONE
   } rds_back_state_type;

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      logic signed [31:0] r;
      if (v > 36'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -36'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

FILE: sv/reaction_diffusion_stencil_step.sv
// ----------------------------------------------------------------------------
// reaction_diffusion_stencil_step: five-point reaction-diffusion cell update
// Streams grid cells in raster order and returns updated densities.
// ----------------------------------------------------------------------------
// Grid cells arrive as words in row-major order, each with a density and a
// carrying capacity in unsigned Q8.8. For every cell the block returns the
// diffusion term r times the five-point Laplacian (zero outside the frame),
// the logistic growth term, and the new density clamped to 0..65535. A result
// appears one row plus one cell after its own cell, so a drain word must be
// sent for each result still pending at the end of a frame. The front accepts
// one word per clock as long as its two-entry job queue has room. Each result
// is then worked out by the back engine in order: the five taps from the
// single read port of the history memory, two arithmetic steps, a 33-step
// bit-serial divide for the growth quotient and a load of the output register.
// The back engine takes a new job only once it is idle again, so that divide
// loop sets the sustained rate for a frame. Writing frame_rows or frame_cols
// restarts the frame and drops pending results; the user must see that
// registers are written only while the block is idle, as the block itself
// does not enforce it.
// ----------------------------------------------------------------------------
module reaction_diffusion_stencil_step import rds_pkg::*; #(
   parameter int MAX_COLS = MAX_COLS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rds_req_type       req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rds_rsp_type       rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [CSR_W-1:0]  csr_wdata
);

   // The history ring keeps two rows plus a little slack for the cells that
   // the front may store while older jobs still wait in the queue.
   localparam int RING     = 2 * MAX_COLS + 4 + JOBQ_DEPTH;
   localparam int AW       = $clog2(RING);
   localparam int COLS_LIM = (MAX_COLS < 2047) ? MAX_COLS : 2047;
   localparam int ROWS_LIM = (MAX_ROWS < 2047) ? MAX_ROWS : 2047;
   localparam int COLS_RST = (COLS_LIM < 1024) ? COLS_LIM : 1024;
   localparam int ROWS_RST = (ROWS_LIM < 1024) ? ROWS_LIM : 1024;
   localparam int JOB_W    = NUM_TAPS * AW + $bits(rds_flags_type);

   // Configuration registers.
   logic [15:0]      rate_ff, rate_in;
   logic [DIM_W-1:0] rows_ff, rows_in;
   logic [DIM_W-1:0] cols_ff, cols_in;
   logic [DIM_W-1:0] dim_sat;
   logic             restart;

   // Front to queue to back.
   logic                        ring_we;
   logic [AW-1:0]               ring_waddr, ring_raddr;
   rds_cell_type                ring_wdata, ring_rdata;
   logic                        fr_job_valid, q_full, q_valid, bk_pop;
   rds_flags_type               fr_flags, bk_flags;
   logic [NUM_TAPS-1:0][AW-1:0] fr_addr, bk_addr;
   logic [JOB_W-1:0]            q_din, q_dout;

   // A frame size is forced into 1..limit; the limit depends on which one.
   always_comb begin
      dim_sat = csr_wdata[DIM_W-1:0];
      if (dim_sat == '0) begin
         dim_sat = DIM_W'(1);
      end
      if (csr_index == CSR_FRAME_ROWS) begin
         if (dim_sat > DIM_W'(ROWS_LIM)) begin
            dim_sat = DIM_W'(ROWS_LIM);
         end
      end else if (dim_sat > DIM_W'(COLS_LIM)) begin
         dim_sat = DIM_W'(COLS_LIM);
      end

      rate_in = rate_ff;
      rows_in = rows_ff;
      cols_in = cols_ff;
      restart = 1'b0;
      if (csr_we) begin
         case (csr_index)
            CSR_DIFF_RATE: begin
               rate_in = csr_wdata[15:0];
            end
            CSR_FRAME_ROWS: begin
               rows_in = dim_sat;
               restart = 1'b1;
            end
            CSR_FRAME_COLS: begin
               cols_in = dim_sat;
               restart = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= '0;
         rows_ff <= DIM_W'(ROWS_RST);
         cols_ff <= DIM_W'(COLS_RST);
      end else begin
         rate_ff <= rate_in;
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   rds_front #(
      .MAX_COLS (MAX_COLS),
      .RING     (RING),
      .AW       (AW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .restart    (restart),
      .frame_rows (rows_ff),
      .frame_cols (cols_ff),
      .ring_we    (ring_we),
      .ring_waddr (ring_waddr),
      .ring_wdata (ring_wdata),
      .job_valid  (fr_job_valid),
      .job_full   (q_full),
      .job_flags  (fr_flags),
      .job_addr   (fr_addr)
   );

   rds_ring #(
      .DEPTH (RING),
      .AW    (AW)
   ) u_ring (
      .clock (clock),
      .we    (ring_we),
      .waddr (ring_waddr),
      .wdata (ring_wdata),
      .raddr (ring_raddr),
      .rdata (ring_rdata)
   );

   assign q_din = {fr_flags, fr_addr};
   assign {bk_flags, bk_addr} = q_dout;

   rds_queue #(
      .W (JOB_W)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (fr_job_valid),
      .din   (q_din),
      .full  (q_full),
      .pop   (bk_pop),
      .valid (q_valid),
      .dout  (q_dout)
   );

   rds_back #(
      .AW (AW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (q_valid),
      .job_pop    (bk_pop),
      .job_flags  (bk_flags),
      .job_addr   (bk_addr),
      .diff_rate  (rate_ff),
      .ring_raddr (ring_raddr),
      .ring_rdata (ring_rdata),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: sv/rds_ring.sv
// ----------------------------------------------------------------------------
// rds_ring: cell history memory
// One write port and one registered read port over the recent cells.
// ----------------------------------------------------------------------------
module rds_ring import rds_pkg::*; #(
   parameter int DEPTH = 2 * MAX_COLS_DEF + 4 + JOBQ_DEPTH,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  rds_cell_type  wdata,
   input  logic [AW-1:0] raddr,
   output rds_cell_type  rdata
);

   rds_cell_type mem [DEPTH];
   rds_cell_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/rds_queue.sv
// ----------------------------------------------------------------------------
// rds_queue: job queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module rds_queue import rds_pkg::*; #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] din,
   output logic         full,
   input  logic         pop,
   output logic         valid,
   output logic [W-1:0] dout
);

   localparam int QAW = $clog2(JOBQ_DEPTH);
   localparam int QCW = $clog2(JOBQ_DEPTH + 1);

   logic [W-1:0]   mem_ff [JOBQ_DEPTH];
   logic [QAW-1:0] wr_ff, wr_in;
   logic [QAW-1:0] rd_ff, rd_in;
   logic [QCW-1:0] cnt_ff, cnt_in;
   logic           do_push, do_pop;

   assign full    = (cnt_ff == QCW'(JOBQ_DEPTH));
   assign valid   = (cnt_ff != '0);
   assign dout    = mem_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= din;
      end
   end

endmodule

FILE: sv/rds_front.sv
// ----------------------------------------------------------------------------
// rds_front: word intake
// Stores cells, tracks the pending count and the position of the oldest
// pending result, and issues one job per result with its tap addresses.
// ----------------------------------------------------------------------------
module rds_front import rds_pkg::*; #(
   parameter int MAX_COLS = MAX_COLS_DEF,
   parameter int RING     = 2 * MAX_COLS + 4 + JOBQ_DEPTH,
   parameter int AW       = $clog2(RING)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  rds_req_type                req_data,
   input  logic                       restart,
   input  logic [DIM_W-1:0]           frame_rows,
   input  logic [DIM_W-1:0]           frame_cols,
   output logic                       ring_we,
   output logic [AW-1:0]              ring_waddr,
   output rds_cell_type               ring_wdata,
   output logic                       job_valid,
   input  logic                       job_full,
   output rds_flags_type              job_flags,
   output logic [NUM_TAPS-1:0][AW-1:0] job_addr
);

   localparam int COLS_LIM = (MAX_COLS < 2047) ? MAX_COLS : 2047;
   localparam int PW       = $clog2(COLS_LIM + 3);
   localparam int CW       = DIM_W + 1;
   localparam logic [AW:0] RING_V = (AW+1)'(RING);

   logic [AW-1:0]    wp_ff, wp_in;
   logic [PW-1:0]    pend_ff, pend_in;
   logic [DIM_W-1:0] erow_ff, erow_in;
   logic [DIM_W-1:0] ecol_ff, ecol_in;

   logic          accept, is_cell, emit;
   logic [PW-1:0] pc;
   logic [AW-1:0] wpn, base, cols_a;
   logic [CW-1:0] pc_w, cols_w, rows_w, erow_w, ecol_w;

   function automatic logic [AW-1:0] ring_sub(input logic [AW-1:0] a,
                                              input logic [AW-1:0] b);
      logic [AW:0] t;
      t = {1'b0, a} - {1'b0, b};
      if (t[AW]) begin
         t = t + RING_V;
      end
      return t[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a,
                                              input logic [AW-1:0] b);
      logic [AW:0] t;
      t = {1'b0, a} + {1'b0, b};
      if (t >= RING_V) begin
         t = t - RING_V;
      end
      return t[AW-1:0];
   endfunction

   // Every word waits for room in the queue, so a result job always fits.
   assign req_ready = !job_full;
   assign accept    = req_valid && req_ready;
   assign is_cell   = (req_data.opcode == OP_CELL);

   always_comb begin
      pc     = is_cell ? pend_ff + 1'b1 : pend_ff;
      wpn    = is_cell ? ring_add(wp_ff, AW'(1)) : wp_ff;
      pc_w   = CW'(pc);
      cols_w = CW'(frame_cols);
      rows_w = CW'(frame_rows);
      erow_w = CW'(erow_ff);
      ecol_w = CW'(ecol_ff);
      cols_a = AW'(frame_cols);
      emit   = is_cell ? (pc_w > cols_w + 1'b1) : (pend_ff != '0);
      base   = ring_sub(wpn, AW'(pc));

      job_addr[TAP_C] = base;
      job_addr[TAP_U] = ring_sub(base, cols_a);
      job_addr[TAP_D] = ring_add(base, cols_a);
      job_addr[TAP_L] = ring_sub(base, AW'(1));
      job_addr[TAP_R] = ring_add(base, AW'(1));

      job_flags.up    = (erow_ff != '0);
      job_flags.left  = (ecol_ff != '0);
      job_flags.right = (ecol_w + 1'b1 < cols_w) && (pc_w > CW'(1));
      job_flags.down  = (erow_w + 1'b1 < rows_w) && (pc_w > cols_w);
      job_flags.last  = (erow_w + 1'b1 == rows_w) && (ecol_w + 1'b1 == cols_w);

      job_valid  = accept && emit;
      ring_we    = accept && is_cell;
      ring_waddr = wp_ff;
      ring_wdata = '{capacity: req_data.capacity, density: req_data.density};

      wp_in   = accept ? wpn : wp_ff;
      pend_in = pend_ff;
      erow_in = erow_ff;
      ecol_in = ecol_ff;
      if (accept) begin
         pend_in = emit ? pc - 1'b1 : pc;
         if (emit) begin
            if (ecol_w + 1'b1 >= cols_w) begin
               ecol_in = '0;
               erow_in = (erow_w + 1'b1 >= rows_w) ? '0 : erow_ff + 1'b1;
            end else begin
               ecol_in = ecol_ff + 1'b1;
            end
         end
      end
      if (restart) begin
         pend_in = '0;
         erow_in = '0;
         ecol_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         pend_ff <= '0;
         erow_ff <= '0;
         ecol_ff <= '0;
      end else begin
         wp_ff   <= wp_in;
         pend_ff <= pend_in;
         erow_ff <= erow_in;
         ecol_ff <= ecol_in;
      end
   end

endmodule

FILE: sv/rds_back.sv
// ----------------------------------------------------------------------------
// rds_back: result engine
// Reads the five taps, forms the Laplacian and the diffusion product, runs a
// bit-serial divide for the growth quotient and holds the result word.
// ----------------------------------------------------------------------------
module rds_back import rds_pkg::*; #(
   parameter int AW = 11
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        job_valid,
   output logic                        job_pop,
   input  rds_flags_type               job_flags,
   input  logic [NUM_TAPS-1:0][AW-1:0] job_addr,
   input  logic [15:0]                 diff_rate,
   output logic [AW-1:0]               ring_raddr,
   input  rds_cell_type                ring_rdata,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output rds_rsp_type                 rsp_data
);

   localparam int DIV_STEPS = 33;

   rds_back_state_type state_ff, state_in;
   logic [5:0]                  cnt_ff, cnt_in;
   rds_flags_type               flags_ff, flags_in;
   logic [NUM_TAPS-1:0][AW-1:0] addr_ff, addr_in;
   logic [NUM_TAPS-1:0][15:0]   tap_ff, tap_in;
   logic [15:0]                 cap_ff, cap_in;
   logic signed [19:0]          lap_ff, lap_in;
   logic [31:0]                 sq_ff, sq_in;
   logic signed [20:0]          diff_ff, diff_in;
   logic [32:0]                 num_ff, num_in;
   logic [16:0]                 rem_ff, rem_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rds_rsp_type                 rsp_data_ff, rsp_data_in;

   logic [2:0]         ridx, sidx;
   logic [15:0]        up, dn, lf, rt, c;
   logic signed [36:0] prod;
   logic [16:0]        rem_t;
   logic               ge;
   logic signed [34:0] growth;
   logic signed [35:0] nd;
   logic               load;

   assign ridx       = (cnt_ff < 6'd5) ? cnt_ff[2:0] : 3'd0;
   assign sidx       = cnt_ff[2:0] - 3'd1;
   assign ring_raddr = addr_ff[ridx];
   assign job_pop    = (state_ff == BK_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      flags_in    = flags_ff;
      addr_in     = addr_ff;
      tap_in      = tap_ff;
      cap_in      = cap_ff;
      lap_in      = lap_ff;
      sq_in       = sq_ff;
      diff_in     = diff_ff;
      num_in      = num_ff;
      rem_in      = rem_ff;
      rsp_data_in = rsp_data_ff;
      load        = 1'b0;

      c    = tap_ff[TAP_C];
      up   = flags_ff.up    ? tap_ff[TAP_U] : 16'd0;
      dn   = flags_ff.down  ? tap_ff[TAP_D] : 16'd0;
      lf   = flags_ff.left  ? tap_ff[TAP_L] : 16'd0;
      rt   = flags_ff.right ? tap_ff[TAP_R] : 16'd0;
      prod = $signed({1'b0, diff_rate}) * lap_ff;
      rem_t = {rem_ff[15:0], num_ff[32]};
      ge    = (rem_t >= {1'b0, cap_ff});

      // A zero capacity drives growth far below the 32-bit range when the density is nonzero.
      if (cap_ff == 16'd0) begin
         growth = (c != 16'd0) ? -35'sd4294967296 : 35'sd0;
      end else begin
         growth = $signed({19'd0, c}) - $signed({2'd0, num_ff});
      end
      nd = $signed({20'd0, c}) + 36'(diff_ff) + 36'(growth);

      case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               flags_in = job_flags;
               addr_in  = job_addr;
               cnt_in   = '0;
               state_in = BK_READ;
            end
         end
         BK_READ: begin
            if (cnt_ff != 6'd0) begin
               tap_in[sidx] = ring_rdata.density;
               if (cnt_ff == 6'd1) begin
                  cap_in = ring_rdata.capacity;
               end
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'd5) begin
               state_in = BK_LAP;
            end
         end
         BK_LAP: begin
            lap_in = $signed({4'd0, up}) + $signed({4'd0, dn}) + $signed({4'd0, lf})
                   + $signed({4'd0, rt}) - $signed({2'd0, c, 2'd0});
            sq_in    = c * c;
            state_in = BK_MUL;
         end
         BK_MUL: begin
            diff_in  = 21'((prod + 37'sd32768) >>> 16);
            num_in   = {1'b0, sq_ff} + {17'd0, cap_ff >> 1};
            rem_in   = '0;
            cnt_in   = '0;
            state_in = BK_DIV;
         end
         BK_DIV: begin
            rem_in = ge ? rem_t - {1'b0, cap_ff} : rem_t;
            num_in = {num_ff[31:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'(DIV_STEPS - 1)) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load = 1'b1;
               if (nd < 36'sd0) begin
                  rsp_data_in.new_density = 16'd0;
               end else if (nd > 36'sd65535) begin
                  rsp_data_in.new_density = 16'hFFFF;
               end else begin
                  rsp_data_in.new_density = nd[15:0];
               end
               rsp_data_in.diffusion_term = sat32(36'(diff_ff));
               rsp_data_in.growth_term    = sat32(36'(growth));
               rsp_data_in.last_of_frame  = flags_ff.last;
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      flags_ff    <= flags_in;
      addr_ff     <= addr_in;
      tap_ff      <= tap_in;
      cap_ff      <= cap_in;
      lap_ff      <= lap_in;
      sq_ff       <= sq_in;
      diff_ff     <= diff_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

FILE: sv/rds_checker.sv
// ----------------------------------------------------------------------------
// rds_checker: port checks
// Watches the result channel of the stencil step for slips over time.
// ----------------------------------------------------------------------------
module rds_checker import rds_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rds_rsp_type      rsp_data
);

   // No result word may be left over from before reset.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");

   // Positive growth with non-negative diffusion can never clamp to zero.
   a_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.diffusion_term[31] && !rsp_data.growth_term[31]
      && rsp_data.growth_term != 32'sd0 |-> rsp_data.new_density != 16'd0)
      else $error("new density clamped to zero with positive growth");

   // With positive growth, a clamp to zero needs a negative diffusion term.
   a_zero_needs_neg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.new_density == 16'd0 && rsp_data.growth_term > 32'sd0
      |-> rsp_data.diffusion_term[31])
      else $error("zero density without a negative term");

endmodule

bind reaction_diffusion_stencil_step rds_checker u_rds_checker (.*);

FILE: bench/tb_reaction_diffusion_stencil_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_reaction_diffusion_stencil_step: self-checking bench for the stencil step
// Streams grid cells and drain words through the block. An in-bench predictor
// works out every result, and the results are compared field by field.
// ----------------------------------------------------------------------------
// The predictor keeps its own copy of the cell history, frame position and
// backlog of unanswered cells. It updates when a word is accepted on the
// request side and queues the expected result words. A checker compares
// every accepted result word with the oldest queued expectation. Both sides
// idle at random. The receiver also holds off for one long stretch so that
// the block stalls its input. A watchdog ends the run if nothing moves for
// too long.
// ----------------------------------------------------------------------------
module tb_reaction_diffusion_stencil_step;
   import rds_pkg::*;

   localparam int HIST_DEPTH  = 2 * MAX_COLS_DEF + 2;
   localparam int IDLE_PCT    = 20;
   // Quiet time after the last expected word, so the back engine can settle
   // before a register write.
   localparam int SETTLE      = 100;
   localparam int STALL_LIMIT = 5000;
   localparam int LARGE_CELLS = 32;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   rds_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rds_rsp_type rsp_data;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_DIFF_RATE;
   logic [15:0] csr_wdata = '0;

   reaction_diffusion_stencil_step u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Predictor state: the bench's own copy of the cell history and position.
   // ------------------------------------------------------------------------
   int unsigned rate_q016;
   int unsigned rows_in_use;
   int unsigned cols_in_use;
   logic [15:0] hist_density [HIST_DEPTH];
   logic [15:0] hist_capacity [HIST_DEPTH];
   int unsigned hist_wr;
   int unsigned in_row, in_col;
   int unsigned out_row, out_col;
   int unsigned backlog;

   rds_rsp_type expected_results [$];
   int          error_count = 0;

   // Control of the idling on both sides.
   bit          send_idle = 1'b1;
   bit          recv_idle = 1'b1;
   int          hold_len = 0;
   bit          hold_tog = 1'b0;
   bit          hold_seen = 1'b0;
   int          hold_cnt = 0;
   int          quiet_cycles = 0;

   function automatic void next_pos(inout int unsigned r, inout int unsigned c);
      if (c + 1 >= cols_in_use) begin
         c = 0;
         r = (r + 1 >= rows_in_use) ? 0 : r + 1;
      end else begin
         c = c + 1;
      end
   endfunction

   function automatic logic signed [31:0] clip32(input longint v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Computes the update of the oldest unanswered cell and queues it.
   function automatic void predict_oldest_cell();
      int unsigned base;
      longint      ctr, up, down, left, right, lap, diff, growth, nd, k, q;
      rds_rsp_type r;
      base = (hist_wr + HIST_DEPTH - backlog) % HIST_DEPTH;
      ctr = longint'(hist_density[base]);
      k = longint'(hist_capacity[base]);
      up = 0;
      down = 0;
      left = 0;
      right = 0;
      if (out_row > 0)
         up = longint'(hist_density[(base + HIST_DEPTH - cols_in_use) % HIST_DEPTH]);
      if (out_col > 0)
         left = longint'(hist_density[(base + HIST_DEPTH - 1) % HIST_DEPTH]);
      // A neighbour that has not arrived yet (only possible while draining)
      // counts as zero, as does anything past the frame edge.
      if (out_col + 1 < cols_in_use && backlog > 1)
         right = longint'(hist_density[(base + 1) % HIST_DEPTH]);
      if (out_row + 1 < rows_in_use && backlog > cols_in_use)
         down = longint'(hist_density[(base + cols_in_use) % HIST_DEPTH]);
      lap = up + down + left + right - 4 * ctr;
      diff = (longint'(rate_q016) * lap + 32768) >>> 16;
      if (k == 0) begin
         // Zero capacity drives growth to the negative limit for any nonzero
         // density.
         growth = (ctr > 0) ? -(64'sd1 <<< 32) : 0;
      end else begin
         q = (ctr * ctr + k / 2) / k;
         growth = ctr - q;
      end
      nd = ctr + diff + growth;
      if (nd < 0) nd = 0;
      if (nd > 65535) nd = 65535;
      r.new_density = nd[15:0];
      r.diffusion_term = clip32(diff);
      r.growth_term = clip32(growth);
      r.last_of_frame = (out_row + 1 == rows_in_use) && (out_col + 1 == cols_in_use);
      expected_results.push_back(r);
      next_pos(out_row, out_col);
      backlog--;
   endfunction

   function automatic void predict_word(input rds_req_type w);
      if (w.opcode == OP_CELL) begin
         hist_density[hist_wr] = w.density;
         hist_capacity[hist_wr] = w.capacity;
         hist_wr = (hist_wr + 1) % HIST_DEPTH;
         next_pos(in_row, in_col);
         backlog++;
         if (backlog > cols_in_use + 1) predict_oldest_cell();
      end else if (backlog > 0) begin
         predict_oldest_cell();
      end
   endfunction

   function automatic void restart_frame();
      in_row = 0;
      in_col = 0;
      out_row = 0;
      out_col = 0;
      backlog = 0;
   endfunction

   // ------------------------------------------------------------------------
   // Driving tasks. All of them start and end at a rising edge.
   // ------------------------------------------------------------------------
   task automatic csr_write(input csr_index_type idx, input logic [15:0] value);
      int unsigned v;
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_DIFF_RATE: begin
            rate_q016 = 32'(value);
         end
         CSR_FRAME_ROWS, CSR_FRAME_COLS: begin
            v = 32'(value & 16'h07FF);
            if (v < 1) v = 1;
            if (idx == CSR_FRAME_ROWS) begin
               rows_in_use = (v > MAX_ROWS) ? MAX_ROWS : v;
            end else begin
               cols_in_use = (v > MAX_COLS_DEF) ? MAX_COLS_DEF : v;
            end
            restart_frame();
         end
         default: begin
         end
      endcase
   endtask

   // Sends one word. Valid is sampled against ready at the falling edge,
   // where both are stable, and the word counts as taken at the next rise.
   task automatic send_word(input rds_req_type w);
      while (send_idle && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      predict_word(w);
   endtask

   task automatic send_cell(input logic [15:0] dens, input logic [15:0] cap);
      rds_req_type w;
      w.opcode = OP_CELL;
      w.density = dens;
      w.capacity = cap;
      send_word(w);
   endtask

   task automatic send_drain();
      rds_req_type w;
      w.opcode = OP_DRAIN;
      w.density = 16'($urandom_range(65535));
      w.capacity = 16'($urandom_range(65535));
      send_word(w);
   endtask

   function automatic logic [15:0] random_density();
      logic [15:0] d;
      case ($urandom_range(5))
         0: d = 16'($urandom_range(255));
         1: d = 16'hFFFF - 16'($urandom_range(255));
         default: d = 16'($urandom_range(65535));
      endcase
      return d;
   endfunction

   function automatic logic [15:0] random_capacity();
      logic [15:0] k;
      case ($urandom_range(7))
         0: k = 16'($urandom_range(1, 4));
         1: k = 16'hFFFF - 16'($urandom_range(3));
         default: k = 16'($urandom_range(1, 65535));
      endcase
      return k;
   endfunction

   task automatic drain_frame();
      while (backlog > 0) send_drain();
   endtask

   // Drops valid and waits until every expected word is in, then lets the
   // back engine go quiet so the block is idle for a register write.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Result side: ready pattern, checker and watchdog.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_tog != hold_seen) begin
         hold_seen <= hold_tog;
         hold_cnt <= hold_len;
         rsp_ready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !recv_idle || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   always @(negedge clock) begin
      rds_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result word", longint'(rsp_data.new_density), -1);
         end else begin
            want = expected_results.pop_front();
            if (rsp_data.new_density !== want.new_density)
               report_mismatch("new_density", longint'(rsp_data.new_density),
                               longint'(want.new_density));
            if (rsp_data.diffusion_term !== want.diffusion_term)
               report_mismatch("diffusion_term", longint'(rsp_data.diffusion_term),
                               longint'(want.diffusion_term));
            if (rsp_data.growth_term !== want.growth_term)
               report_mismatch("growth_term", longint'(rsp_data.growth_term),
                               longint'(want.growth_term));
            if (rsp_data.last_of_frame !== want.last_of_frame)
               report_mismatch("last_of_frame", longint'(rsp_data.last_of_frame),
                               longint'(want.last_of_frame));
         end
      end
   end

   always @(negedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: nothing moved for %0d cycles", STALL_LIMIT);
            $display("Verification failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // A 3x3 frame with the density and capacity extremes, zero capacity with
   // and without density, and drains before, during and past the backlog.
   task automatic test_directed();
      csr_write(CSR_DIFF_RATE, 16'h8000);
      csr_write(CSR_FRAME_ROWS, 16'd3);
      csr_write(CSR_FRAME_COLS, 16'd3);
      send_drain();
      send_cell(16'h0000, 16'hFFFF);
      send_cell(16'hFFFF, 16'h0001);
      send_cell(16'h0001, 16'hFFFF);
      send_cell(16'hFFFF, 16'h0000);
      send_cell(16'h0000, 16'h0000);
      send_drain();
      send_cell(16'h8000, 16'h8000);
      send_cell(16'h7FFF, 16'h5555);
      send_cell(16'hAAAA, 16'h0002);
      send_cell(16'h0100, 16'h0100);
      drain_frame();
      send_drain();
      wait_drained();
   endtask

   // Smallest frames at both rate extremes; frame size writes of zero and of a
   // value whose low eleven bits are zero become one.
   task automatic test_rate_extremes();
      logic [15:0] rates [2] = '{16'hFFFF, 16'h0000};
      foreach (rates[i]) begin
         csr_write(CSR_DIFF_RATE, rates[i]);
         csr_write(CSR_FRAME_ROWS, 16'h0800);
         csr_write(CSR_FRAME_COLS, 16'h0000);
         repeat (6) send_cell(random_density(), random_capacity());
         drain_frame();
         wait_drained();
      end
   endtask

   // Random small frames with random content and drains mixed in.
   task automatic test_random_frames();
      int unsigned nframes;
      repeat (8) begin
         csr_write(CSR_DIFF_RATE, 16'($urandom_range(65535)));
         csr_write(CSR_FRAME_ROWS, 16'($urandom_range(1, 6)));
         csr_write(CSR_FRAME_COLS, 16'($urandom_range(1, 8)));
         // Often two frames back to back with no restart in between.
         nframes = $urandom_range(1, 2);
         repeat (nframes * rows_in_use * cols_in_use) begin
            if ($urandom_range(99) < 8) send_drain();
            send_cell(random_density(), random_capacity());
         end
         drain_frame();
         if ($urandom_range(1)) send_drain();
         wait_drained();
      end
   endtask

   // The receiver holds off while cells keep coming so the block fills and
   // stalls its input; later the sender pauses in mid-frame until every
   // expected word has arrived.
   task automatic test_pressure();
      csr_write(CSR_DIFF_RATE, 16'($urandom_range(65535)));
      csr_write(CSR_FRAME_ROWS, 16'd4);
      csr_write(CSR_FRAME_COLS, 16'd4);
      hold_len = 600;
      hold_tog = ~hold_tog;
      repeat (12) send_cell(random_density(), random_capacity());
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() > 0) @(posedge clock);
      repeat (4) send_cell(random_density(), random_capacity());
      drain_frame();
      wait_drained();
   endtask

   // The start of the largest frame sizes, one dimension at a time, with no
   // idling at all.
   task automatic test_large_frames();
      send_idle = 1'b0;
      recv_idle = 1'b0;
      csr_write(CSR_DIFF_RATE, 16'($urandom_range(65535)));
      csr_write(CSR_FRAME_ROWS, 16'hFFFF);
      csr_write(CSR_FRAME_COLS, 16'd1);
      repeat (LARGE_CELLS) send_cell(random_density(), random_capacity());
      drain_frame();
      wait_drained();
      csr_write(CSR_FRAME_ROWS, 16'd1);
      csr_write(CSR_FRAME_COLS, 16'd1024);
      repeat (LARGE_CELLS) send_cell(random_density(), random_capacity());
      drain_frame();
      wait_drained();
      send_idle = 1'b1;
      recv_idle = 1'b1;
   endtask

   initial begin
      rate_q016 = 0;
      rows_in_use = 1024;
      cols_in_use = 1024;
      hist_wr = 0;
      restart_frame();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_rate_extremes();
      test_random_frames();
      test_pressure();
      test_large_frames();
      wait_drained();
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
